@@ rtl/rda_pkg.sv @@
// ----------------------------------------------------------------------------
// rda_pkg: shared types and constants
// Request payloads and fixed-point constants of the rank derivative scorer.
// ----------------------------------------------------------------------------
package rda_pkg;

  localparam int RANK_W = 31;   // Q1.30 rank
  localparam int D_W    = 33;   // signed derivative, Q.30
  localparam int MEAN_W = 33;   // signed running mean
  localparam int MSQ_W  = 47;   // unsigned running mean square, Q.44
  localparam int Z_W    = 32;   // |z|, Q8.24
  localparam int TOT_W  = 48;   // abs sum, Q24.24
  localparam int SC_W   = 63;   // score, Q39.24
  localparam int NUM_W  = 49;   // divider dividend
  localparam int ROOT_W = 24;   // square root result

  localparam logic [SC_W-1:0]  FLOOR_SCORE = SC_W'(64'd2000 << 24);
  localparam logic [SC_W-1:0]  SCORE_CAP   = {SC_W{1'b1}};
  localparam logic [TOT_W-1:0] SUM_CAP     = {TOT_W{1'b1}};
  localparam logic [Z_W-1:0]   Z_NEG_LIM   = 32'h8000_0000;
  localparam logic [Z_W-1:0]   Z_POS_LIM   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [9:0]        node_index;
    logic [RANK_W-1:0] rank_a;
    logic [RANK_W-1:0] rank_b;
    logic              last_node;
  } in_item_t;

  typedef struct packed {
    logic [SC_W-1:0] anomaly_score;
    logic [23:0]     step_index;
  } out_item_t;

endpackage

@@ rtl/rank_derivative_anomaly_score.sv @@
// ----------------------------------------------------------------------------
// rank_derivative_anomaly_score: rank derivative anomaly scorer
// Per-node rank derivatives, z-normalized, reduced to one score per step.
// ----------------------------------------------------------------------------
// One request carries one node's two ranks; nodes of a time step arrive in
// order and the request flagged last_node closes the step and yields one
// result (score and step index). Throughput is set by one shared restoring
// divider and one square root unit, both used in turn for the four
// derivatives of a node. An entry whose deviation is not positive skips the
// square root and the normalizing divide but still runs both running average
// divides, an out-of-range node skips the datapath, and closing a step
// forms the score products, which go through one 32x32 multiplier in two
// halves each.
// in_ready is high only while the sequencer is idle. Per-node history and
// running statistics live in memories that are not cleared at reset.
// ----------------------------------------------------------------------------
module rank_derivative_anomaly_score #(
  parameter int NODES      = 1024,
  parameter int STEP_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rda_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rda_pkg::out_item_t   out_data
);

  localparam int NA    = $clog2(NODES);
  localparam int DEN_W = (STEP_WIDTH + 1 > rda_pkg::ROOT_W) ? STEP_WIDTH + 1
                                                            : rda_pkg::ROOT_W;
  localparam int RW    = rda_pkg::RANK_W;
  localparam int NW    = rda_pkg::NUM_W;

  typedef enum logic [4:0] {
    S_IDLE, S_HRD, S_DIFF, S_SRD, S_MEAN, S_MEANW, S_SQW, S_MSQ, S_DEV,
    S_SQRTW, S_ZW, S_ACC, S_SC_INIT, S_SC_HI, S_SC_LO, S_SC_SUM, S_SC_CMP,
    S_EMIT
  } state_t;

  state_t state_r;

  // request latch
  logic [NA-1:0]  node_r;
  logic [RW-1:0]  a_r, b_r;
  logic           last_r;
  logic [16:0]    node_ext;
  logic           in_rng;

  // memories: history {a1, a2, b1, b2}, statistics {mean, meansq}
  logic [4*RW-1:0] hist_mem [NODES];
  logic [4*RW-1:0] hist_rd_r;
  logic [rda_pkg::MEAN_W+rda_pkg::MSQ_W-1:0] st_mem [4 << NA];
  logic [rda_pkg::MEAN_W+rda_pkg::MSQ_W-1:0] st_rd_r;
  logic hist_we, st_we;

  // per-entry datapath
  logic signed [rda_pkg::D_W-1:0]    d_r [4];
  logic [1:0]                        k_r;
  logic signed [rda_pkg::MEAN_W-1:0] m_r;
  logic [rda_pkg::MSQ_W-1:0]         v_r;
  logic [rda_pkg::MSQ_W-1:0]         x2_r;
  logic                              neg_r;
  logic [rda_pkg::Z_W-1:0]           z_r;

  // step accumulators
  logic [rda_pkg::Z_W-1:0]   max_r [4];
  logic [rda_pkg::TOT_W-1:0] tot_r [4];
  logic [STEP_WIDTH-1:0]     step_r;

  // score
  logic [1:0]                kk_r, jj_r;
  logic [rda_pkg::SC_W-1:0]  sub_r, score_r;
  logic [63:0]               hi_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  // output register
  logic               out_valid_r;
  rda_pkg::out_item_t out_data_r;

  // shared units
  logic               div_start, div_done;
  logic [NW-1:0]      div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  logic               sq_start, sq_done;
  logic [2*rda_pkg::ROOT_W-1:0] sq_op;
  logic [rda_pkg::ROOT_W-1:0]   sq_root;

  // combinational helpers
  logic signed [rda_pkg::D_W-1:0]    d_k;
  logic [rda_pkg::D_W-1:0]           d_mag;
  logic signed [rda_pkg::MEAN_W-1:0] m_old;
  logic [rda_pkg::MSQ_W-1:0]         v_old;
  logic signed [rda_pkg::D_W:0]      dm_old, dm_new;
  logic [rda_pkg::D_W:0]             dm_old_mag, dm_new_mag;
  logic signed [rda_pkg::MSQ_W:0]    dv;
  logic [rda_pkg::MSQ_W:0]           dv_mag;
  logic signed [NW:0]                m_sum, v_sum;
  logic signed [rda_pkg::MSQ_W:0]    dev;
  logic [rda_pkg::MEAN_W-1:0]        m_mag;
  logic [RW+1:0]                     dd0_a, dd1_a, dd0_b, dd1_b;
  logic [RW-1:0]                     a1, a2, b1, b2;
  logic [rda_pkg::TOT_W:0]           tot_sum;
  logic [rda_pkg::Z_W-1:0]           z_sat;
  logic [63:0]                       msum;
  logic                              mcap;
  logic [31:0]                       step_ext;

  assign node_ext = {7'd0, in_data.node_index};
  assign in_rng   = (node_ext < 17'(NODES));
  assign in_ready = (state_r == S_IDLE);

  assign {a1, a2, b1, b2} = hist_rd_r;

  // derivatives, 33-bit signed two's complement
  assign dd0_a = {2'b00, a_r} - {2'b00, a1};
  assign dd1_a = {2'b00, a_r} - {1'b0, a1, 1'b0} + {2'b00, a2};
  assign dd0_b = {2'b00, b_r} - {2'b00, b1};
  assign dd1_b = {2'b00, b_r} - {1'b0, b1, 1'b0} + {2'b00, b2};

  assign d_k   = d_r[k_r];
  assign d_mag = d_k[rda_pkg::D_W-1] ? -d_k : d_k;
  // step 0 divides by one, so the running averages start from zero there
  assign {m_old, v_old} = (step_r == '0) ? '0 : st_rd_r;

  assign dm_old     = $signed({d_k[rda_pkg::D_W-1], d_k}) -
                      $signed({m_old[rda_pkg::MEAN_W-1], m_old});
  assign dm_old_mag = dm_old[rda_pkg::D_W] ? -dm_old : dm_old;
  assign dm_new     = $signed({d_k[rda_pkg::D_W-1], d_k}) -
                      $signed({m_r[rda_pkg::MEAN_W-1], m_r});
  assign dm_new_mag = dm_new[rda_pkg::D_W] ? -dm_new : dm_new;
  assign dv         = $signed({1'b0, x2_r}) - $signed({1'b0, v_old});
  assign dv_mag     = dv[rda_pkg::MSQ_W] ? -dv : dv;

  // running updates: old + signed truncated quotient
  assign m_sum = $signed((NW+1)'(m_old)) +
                 (neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot}));
  assign v_sum = $signed({{(NW+1-rda_pkg::MSQ_W){1'b0}}, v_old}) +
                 (neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot}));

  assign m_mag = m_r[rda_pkg::MEAN_W-1] ? -m_r : m_r;
  assign dev   = $signed({1'b0, v_r}) - $signed({1'b0, prod_r[62:16]});

  assign z_sat = neg_r ?
      ((div_quot > NW'(rda_pkg::Z_NEG_LIM)) ? rda_pkg::Z_NEG_LIM
                                            : div_quot[rda_pkg::Z_W-1:0]) :
      ((div_quot > NW'(rda_pkg::Z_POS_LIM)) ? rda_pkg::Z_POS_LIM
                                            : div_quot[rda_pkg::Z_W-1:0]);

  assign tot_sum = {1'b0, tot_r[k_r]} + (rda_pkg::TOT_W+1)'(z_r);

  // (hi << 8) + (lo >> 24), saturating
  assign msum = {hi_r[55:0], 8'h00} + {24'd0, prod_r[63:24]};
  assign mcap = (hi_r[63:55] != 9'd0) || (msum > {1'b0, rda_pkg::SCORE_CAP});

  assign step_ext = 32'(step_r);

  // shared unit operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(dm_old_mag);
    div_den   = DEN_W'(step_r) + 1'b1;
    sq_start  = 1'b0;
    sq_op     = dev[2*rda_pkg::ROOT_W-1:0];
    mul_a     = d_mag[31:0];
    mul_b     = d_mag[31:0];
    unique case (state_r)
      S_MEAN: begin
        div_start = 1'b1;
        div_num   = NW'(dm_old_mag);
      end
      S_MEANW: begin
        div_start = div_done;
        div_num   = NW'(dv_mag);
      end
      S_DEV: begin
        sq_start = !dev[rda_pkg::MSQ_W] && (dev != '0);
      end
      S_SQRTW: begin
        div_start = sq_done;
        div_num   = NW'({dm_new_mag, 16'h0000});
        div_den   = DEN_W'(sq_root);
      end
      S_MSQ: begin
        mul_a = m_mag[31:0];
        mul_b = m_mag[31:0];
      end
      S_SC_HI: begin
        mul_a = 32'(sub_r[62:32]);
        mul_b = max_r[jj_r];
      end
      S_SC_LO: begin
        mul_a = sub_r[31:0];
        mul_b = max_r[jj_r];
      end
      default: begin
      end
    endcase
  end

  assign hist_we = (state_r == S_DIFF);
  assign st_we   = (state_r == S_DEV);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hist_rd_r <= hist_mem[NA'(in_data.node_index)];
    end
    if (hist_we) begin
      hist_mem[node_r] <= {a_r, a1, b_r, b1};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SRD) begin
      st_rd_r <= st_mem[{k_r, node_r}];
    end
    if (st_we) begin
      st_mem[{k_r, node_r}] <= {m_r, v_r};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        max_r[i] <= '0;
        tot_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            node_r <= NA'(in_data.node_index);
            a_r    <= in_data.rank_a;
            b_r    <= in_data.rank_b;
            last_r <= in_data.last_node;
            if (in_rng) begin
              state_r <= S_HRD;
            end else if (in_data.last_node) begin
              state_r <= S_SC_INIT;
              kk_r    <= 2'd0;
              score_r <= rda_pkg::FLOOR_SCORE;
            end
          end
        end
        S_HRD: begin
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          // undefined derivatives read as zero
          d_r[0]  <= (step_r != '0) ? $signed(dd0_a[rda_pkg::D_W-1:0]) : '0;
          d_r[1]  <= (step_r > STEP_WIDTH'(1)) ? $signed(dd1_a[rda_pkg::D_W-1:0]) : '0;
          d_r[2]  <= (step_r != '0) ? $signed(dd0_b[rda_pkg::D_W-1:0]) : '0;
          d_r[3]  <= (step_r > STEP_WIDTH'(1)) ? $signed(dd1_b[rda_pkg::D_W-1:0]) : '0;
          k_r     <= 2'd0;
          state_r <= S_SRD;
        end
        S_SRD: begin
          state_r <= S_MEAN;
        end
        S_MEAN: begin
          x2_r    <= prod_r[62:16];
          neg_r   <= dm_old[rda_pkg::D_W];
          state_r <= S_MEANW;
        end
        S_MEANW: begin
          if (div_done) begin
            m_r     <= m_sum[rda_pkg::MEAN_W-1:0];
            neg_r   <= dv[rda_pkg::MSQ_W];
            state_r <= S_SQW;
          end
        end
        S_SQW: begin
          if (div_done) begin
            v_r     <= v_sum[rda_pkg::MSQ_W-1:0];
            state_r <= S_MSQ;
          end
        end
        S_MSQ: begin
          state_r <= S_DEV;
        end
        S_DEV: begin
          if (!dev[rda_pkg::MSQ_W] && (dev != '0)) begin
            state_r <= S_SQRTW;
          end else begin
            // zero or negative deviation: entry stays unnormalized, Q.30 -> Q.24
            z_r     <= rda_pkg::Z_W'(d_mag >> 6);
            state_r <= S_ACC;
          end
        end
        S_SQRTW: begin
          if (sq_done) begin
            neg_r   <= dm_new[rda_pkg::D_W];
            state_r <= S_ZW;
          end
        end
        S_ZW: begin
          if (div_done) begin
            z_r     <= z_sat;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (z_r > max_r[k_r]) begin
            max_r[k_r] <= z_r;
          end
          tot_r[k_r] <= (tot_sum > {1'b0, rda_pkg::SUM_CAP}) ? rda_pkg::SUM_CAP
                                                             : tot_sum[rda_pkg::TOT_W-1:0];
          if (k_r != 2'd3) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SRD;
          end else if (last_r) begin
            state_r <= S_SC_INIT;
            kk_r    <= 2'd0;
            score_r <= rda_pkg::FLOOR_SCORE;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SC_INIT: begin
          sub_r   <= rda_pkg::SC_W'(tot_r[kk_r]);
          jj_r    <= 2'd0;
          state_r <= S_SC_HI;
        end
        S_SC_HI: begin
          if (jj_r == kk_r) begin
            jj_r    <= jj_r + 1'b1;
            state_r <= (jj_r == 2'd3) ? S_SC_CMP : S_SC_HI;
          end else begin
            state_r <= S_SC_LO;
          end
        end
        S_SC_LO: begin
          hi_r    <= prod_r;
          state_r <= S_SC_SUM;
        end
        S_SC_SUM: begin
          sub_r   <= mcap ? rda_pkg::SCORE_CAP : msum[rda_pkg::SC_W-1:0];
          jj_r    <= jj_r + 1'b1;
          state_r <= (jj_r == 2'd3) ? S_SC_CMP : S_SC_HI;
        end
        S_SC_CMP: begin
          if (sub_r > score_r) begin
            score_r <= sub_r;
          end
          if (kk_r == 2'd3) begin
            state_r <= S_EMIT;
          end else begin
            kk_r    <= kk_r + 1'b1;
            state_r <= S_SC_INIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.anomaly_score <= score_r;
            out_data_r.step_index    <= step_ext[23:0];
            step_r                   <= step_r + 1'b1;
            for (int i = 0; i < 4; i++) begin
              max_r[i] <= '0;
              tot_r[i] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rda_div #(
    .NUM_W (NW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  rda_sqrt #(
    .ROOT_W (rda_pkg::ROOT_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .op    (sq_op),
    .done  (sq_done),
    .root  (sq_root)
  );

`ifndef SYNTH
  // closing a step advances the step counter and clears the sums
  a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=>
      (step_r == STEP_WIDTH'($past(step_r) + 1'b1)) && (tot_r[0] == '0))
    else $error("step close did not advance or clear");

  // the emitted score never drops below the floor
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (score_r >= rda_pkg::FLOOR_SCORE))
    else $error("score below floor");

  // the divider is only started from a state that waits for it
  a_div_use: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_MEANW || state_r == S_SQW || state_r == S_ZW))
    else $error("divider started with no consumer");
`endif

endmodule

@@ rtl/rda_div.sv @@
// ----------------------------------------------------------------------------
// rda_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rda_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], q_bit};
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ rtl/rda_sqrt.sv @@
// ----------------------------------------------------------------------------
// rda_sqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rda_sqrt #(
  parameter int ROOT_W = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] op,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [2*ROOT_W-1:0] op_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                fits;

  assign rem_sh = {rem_r[ROOT_W-1:0], op_r[2*ROOT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= op;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], fits};
        op_r   <= {op_r[2*ROOT_W-3:0], 2'b00};
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: rank derivative anomaly scorer regression
// Streams node requests in time steps, predicts each step score in-bench,
// and checks every result against the oldest predicted score.
// ----------------------------------------------------------------------------
module tb;

  localparam int NODE_CNT = 1024;
  localparam int RANDOM_ITEMS = 900;
  localparam bit [63:0] SCORE_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] SUM_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam bit [63:0] FLOOR_Q24 = 64'd2000 << 24;
  localparam longint ONE_Q30 = 64'd1 << 30;

  typedef struct {
    rda_pkg::in_item_t item;
    bit       drain;   // hold this request until all scores are back
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rda_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  rda_pkg::out_item_t out_data;

  pending_t  pending[$];
  rda_pkg::out_item_t score_q[$];
  int        errors;
  int        gap;
  int        stall;
  bit        burst;    // stretch with no idling on the request side
  int        node_pool[8] = '{0, 1, 2, 3, 511, 512, 1022, 1023};
  longint    gen_a[int];
  longint    gen_b[int];

  // predictor state
  longint    prev_a[int], prev2_a[int], prev_b[int], prev2_b[int];
  longint    mean_st[int], msq_st[int];
  bit [63:0] step_no;
  bit [63:0] peak[4];
  bit [63:0] total[4];

  rank_derivative_anomaly_score dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint div_toward_zero(longint num, bit [63:0] den);
    bit [63:0] q;
    q = mag(num) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // (a*b)>>24 with saturation; a fits 63 bits, b 32 bits
  function automatic bit [63:0] q24_mul_sat(bit [63:0] a, bit [63:0] b);
    bit [63:0] hi, lo, r;
    hi = (a >> 32) * b;
    lo = (a & 64'hFFFF_FFFF) * b;
    if ((hi >> 55) != 0) return SCORE_SAT;
    r = (hi << 8) + (lo >> 24);
    return r > SCORE_SAT ? SCORE_SAT : r;
  endfunction

  // |z| of one derivative, updating that entry's running mean and mean square
  function automatic bit [63:0] z_magnitude(int k, int node, longint d);
    int        idx;
    longint    m, v, x2, dev, diff;
    bit [63:0] sd, q;
    idx = k * NODE_CNT + node;
    m = mean_st.exists(idx) ? mean_st[idx] : 0;
    v = msq_st.exists(idx) ? msq_st[idx] : 0;
    x2 = longint'((mag(d) * mag(d)) >> 16);
    m = m + div_toward_zero(d - m, step_no + 1);
    v = v + div_toward_zero(x2 - v, step_no + 1);
    mean_st[idx] = m;
    msq_st[idx] = v;
    dev = v - longint'((mag(m) * mag(m)) >> 16);
    // zero or negative deviation: raw derivative in Q8.24
    if (dev <= 0) return mag(d) >> 6;
    sd = int_sqrt(64'(dev));
    diff = d - m;
    q = (mag(diff) << 16) / sd;
    if (diff < 0) return q > 64'h8000_0000 ? 64'h8000_0000 : q;
    return q > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : q;
  endfunction

  task automatic predict_score(rda_pkg::in_item_t it);
    int        n;
    longint    a, b, a1, a2, b1, b2;
    longint    d[4];
    bit [63:0] z, sub, best;
    rda_pkg::out_item_t exp_item;
    n = it.node_index;
    a = it.rank_a;
    b = it.rank_b;
    a1 = prev_a.exists(n) ? prev_a[n] : 0;
    a2 = prev2_a.exists(n) ? prev2_a[n] : 0;
    b1 = prev_b.exists(n) ? prev_b[n] : 0;
    b2 = prev2_b.exists(n) ? prev2_b[n] : 0;
    d = '{0, 0, 0, 0};
    if (step_no > 0) begin
      d[0] = a - a1;
      d[2] = b - b1;
    end
    if (step_no > 1) begin
      d[1] = a - 2 * a1 + a2;
      d[3] = b - 2 * b1 + b2;
    end
    prev2_a[n] = a1; prev_a[n] = a;
    prev2_b[n] = b1; prev_b[n] = b;
    for (int k = 0; k < 4; k++) begin
      z = z_magnitude(k, n, d[k]);
      if (z > peak[k]) peak[k] = z;
      total[k] = total[k] + z;
      if (total[k] > SUM_SAT) total[k] = SUM_SAT;
    end
    if (it.last_node) begin
      best = FLOOR_Q24;
      for (int k = 0; k < 4; k++) begin
        sub = total[k];
        for (int j = 0; j < 4; j++)
          if (j != k) sub = q24_mul_sat(sub, peak[j]);
        if (sub > best) best = sub;
      end
      exp_item.anomaly_score = best[62:0];
      exp_item.step_index = step_no[23:0];
      score_q.push_back(exp_item);
      step_no = (step_no + 1) & 64'hFF_FFFF;
      peak = '{0, 0, 0, 0};
      total = '{0, 0, 0, 0};
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  task automatic add_req(int node, longint a, longint b, bit last, bit drain = 0);
    pending_t p;
    p.item.node_index = node[9:0];
    p.item.rank_a = a[30:0];
    p.item.rank_b = b[30:0];
    p.item.last_node = last;
    p.drain = drain;
    pending.push_back(p);
    gen_a[node] = a;
    gen_b[node] = b;
  endtask

  // request driver; the predictor runs on every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap <= 0;
      burst <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_score(in_data);
        if ($urandom_range(0, 63) == 0) burst <= ~burst;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          in_valid <= 1'b0;
          gap <= gap - 1;
        end else if (pending.size() == 0 ||
                     (pending[0].drain && score_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= pending[0].item;
          pending.pop_front();
          in_valid <= 1'b1;
          gap <= burst ? 0 : pick_gap();
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result score=%0h step=%0d", $time,
                   out_data.anomaly_score, out_data.step_index);
          errors++;
        end else begin
          if (out_data.anomaly_score !== score_q[0].anomaly_score) begin
            $display("%0t: anomaly_score expected %0h actual %0h", $time,
                     score_q[0].anomaly_score, out_data.anomaly_score);
            errors++;
          end
          if (out_data.step_index !== score_q[0].step_index) begin
            $display("%0t: step_index expected %0d actual %0d", $time,
                     score_q[0].step_index, out_data.step_index);
            errors++;
          end
          score_q.pop_front();
        end
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall <= stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall <= pick_gap();
      end
    end
  end

  initial begin
    int n_items, cnt, node, mode;
    longint a, b;
    errors = 0;
    step_no = 0;
    peak = '{0, 0, 0, 0};
    total = '{0, 0, 0, 0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;

    // step 0: every pool node twice (repeated node), fills the pool nodes' history
    for (int r = 0; r < 2; r++)
      foreach (node_pool[i])
        add_req(node_pool[i], r ? ONE_Q30 : 0, r ? 0 : ONE_Q30,
                (r == 1) && (i == 7));
    // full-scale swings: largest first and second differences
    add_req(0, ONE_Q30, 0, 0);
    add_req(1023, 0, ONE_Q30, 0);
    add_req(1, 0, ONE_Q30, 1);
    add_req(0, 0, ONE_Q30, 0);
    add_req(1023, ONE_Q30, 0, 0);
    add_req(1, 0, ONE_Q30, 1);  // unchanged rank: zero first differences
    add_req(2, 31'h2AAA_AAAA, 31'h1555_5555, 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // random steps; nodes drawn from the pool so nothing unwritten is read
    cnt = 0;
    while (cnt < RANDOM_ITEMS) begin
      n_items = $urandom_range(1, 6);
      mode = $urandom_range(0, 99);
      for (int i = 0; i < n_items; i++) begin
        node = node_pool[$urandom_range(0, 7)];
        if (mode < 20) begin
          a = gen_a[node];
          b = gen_b[node];
        end else if (mode < 35) begin
          a = $urandom_range(0, 1) ? ONE_Q30 : 0;
          b = $urandom_range(0, 1) ? ONE_Q30 : 0;
        end else if (mode < 50) begin
          a = gen_a[node] + $urandom_range(0, 2000) - 1000;
          b = gen_b[node] + $urandom_range(0, 2000) - 1000;
          if (a < 0) a = 0;
          if (a > ONE_Q30) a = ONE_Q30;
          if (b < 0) b = 0;
          if (b > ONE_Q30) b = ONE_Q30;
        end else begin
          a = $urandom_range(0, 32'h4000_0000);
          b = $urandom_range(0, 32'h4000_0000);
        end
        add_req(node, a, b, i == n_items - 1,
                (i == 0) && ($urandom_range(0, 29) == 0));
        cnt++;
      end
    end

    while (pending.size() != 0 || in_valid || score_q.size() != 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
    if (score_q.size() != 0) begin
      $display("%0t: %0d scores never arrived", $time, score_q.size());
      errors++;
    end
    if (errors == 0)
      $display("rank_derivative_anomaly_score regression: pass");
    else
      $display("rank_derivative_anomaly_score regression: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("rank_derivative_anomaly_score regression: fail");
    $finish;
  end

endmodule
